// File: sv/hsl_pkg.sv
// Shared constants, widths and beat types for the RGB-to-HSL pipeline.
// No dependencies; every other file imports this package.
package hsl_pkg;

    localparam int SAT_FRACTION_BITS = 12;
    localparam int HUE_FRACTION_BITS = 6;

    localparam int CH_W    = 8;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 13;
    localparam int LIGHT_W = 9;

    // Hue in degrees times delta, divided by 60, lands in 0..6*255.
    localparam int SECT_W = 11;

    // Full circle in hue units; a quotient at or above it wraps to 0.
    localparam int HUE_FULL = 360 << HUE_FRACTION_BITS;
    // 2 * 60 * 2^HUE_FRACTION_BITS: doubled for round-half-up.
    localparam int HUE_MUL  = 120 << HUE_FRACTION_BITS;

    localparam int HUE_QW = $clog2(HUE_FULL + 1);
    localparam int SAT_QW = SAT_FRACTION_BITS + 1;
    localparam int DIV_QW = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;
    localparam int DEN_W  = 10;
    localparam int NUM_W  = DEN_W + DIV_QW;

    localparam int FRONT_LAT = 3;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_QW + 1;

    typedef struct packed {
        logic               valid;
        logic               gray;
        logic [LIGHT_W-1:0] light;
    } hsl_side_t;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [DIV_QW-1:0] quo;
    } hsl_lane_t;

    typedef struct packed {
        hsl_side_t side;
        hsl_lane_t hue;
        hsl_lane_t sat;
    } hsl_beat_t;

endpackage

// File: sv/hsl_front.sv
// Front end: max/min, sector, divider operands (three register stages).
// Depends on hsl_pkg.
module hsl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [hsl_pkg::CH_W-1:0]    red,
    input  logic [hsl_pkg::CH_W-1:0]    green,
    input  logic [hsl_pkg::CH_W-1:0]    blue,
    output hsl_pkg::hsl_beat_t          beat_out
);
    import hsl_pkg::*;

    localparam logic [2:0] BASE_RED      = 3'd0;
    localparam logic [2:0] BASE_GREEN    = 3'd2;
    localparam logic [2:0] BASE_BLUE     = 3'd4;
    localparam logic [2:0] BASE_RED_WRAP = 3'd6;

    // ---- stage 1: extremes and sector ----
    logic                    s1_valid_reg;
    logic [CH_W-1:0]         s1_delta_reg, s1_delta_next;
    logic [LIGHT_W-1:0]      s1_sum_reg, s1_sum_next;
    logic signed [CH_W:0]    s1_diff_reg, s1_diff_next;
    logic [2:0]              s1_base_reg, s1_base_next;

    logic [CH_W-1:0] mx, mn;
    logic            r_max, g_max;

    always_comb
    begin
        r_max = (red >= green) && (red >= blue);
        g_max = !r_max && (green >= blue);
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        s1_delta_next = mx - mn;
        s1_sum_next   = LIGHT_W'(mx) + LIGHT_W'(mn);
        if (r_max)
        begin
            s1_diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
            s1_base_next = s1_diff_next[CH_W] ? BASE_RED_WRAP : BASE_RED;
        end
        else if (g_max)
        begin
            s1_diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
            s1_base_next = BASE_GREEN;
        end
        else
        begin
            s1_diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
            s1_base_next = BASE_BLUE;
        end
    end

    // ---- stage 2: sector value and saturation divisor ----
    logic                    s2_valid_reg;
    logic [SECT_W-1:0]       s2_sect_reg, s2_sect_next;
    logic [CH_W-1:0]         s2_delta_reg;
    logic [LIGHT_W-1:0]      s2_den_reg, s2_den_next;
    logic [LIGHT_W-1:0]      s2_sum_reg;
    logic                    s2_gray_reg;
    logic [SECT_W-1:0]       base_prod;

    always_comb
    begin
        base_prod   = SECT_W'(s1_base_reg) * SECT_W'(s1_delta_reg);
        s2_sect_next = base_prod + SECT_W'(s1_diff_reg);
        s2_den_next  = (s1_sum_reg <= LIGHT_W'(255)) ? s1_sum_reg
                                                     : LIGHT_W'(510) - s1_sum_reg;
    end

    // ---- stage 3: numerators and doubled divisors ----
    logic      s3_valid_reg;
    hsl_beat_t s3_reg, s3_next;

    always_comb
    begin
        s3_next            = '0;
        s3_next.side.gray  = s2_gray_reg;
        s3_next.side.light = s2_sum_reg;
        s3_next.hue.rem    = NUM_W'(s2_sect_reg) * NUM_W'(HUE_MUL) + NUM_W'(s2_delta_reg);
        s3_next.hue.den    = DEN_W'({s2_delta_reg, 1'b0});
        s3_next.sat.rem    = (NUM_W'(s2_delta_reg) << (SAT_FRACTION_BITS + 1))
                             + NUM_W'(s2_den_reg);
        s3_next.sat.den    = DEN_W'({s2_den_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_delta_reg <= s1_delta_next;
        s1_sum_reg   <= s1_sum_next;
        s1_diff_reg  <= s1_diff_next;
        s1_base_reg  <= s1_base_next;
        s2_sect_reg  <= s2_sect_next;
        s2_delta_reg <= s1_delta_reg;
        s2_den_reg   <= s2_den_next;
        s2_sum_reg   <= s1_sum_reg;
        s2_gray_reg  <= (s1_delta_reg == '0);
        s3_reg       <= s3_next;
    end

    always_comb
    begin
        beat_out            = s3_reg;
        beat_out.side.valid = s3_valid_reg;
    end

endmodule

// File: sv/hsl_div_step.sv
// One registered restoring-division step, run on the hue and saturation lanes.
// Depends on hsl_pkg.
module hsl_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  hsl_pkg::hsl_beat_t beat_in,
    output hsl_pkg::hsl_beat_t beat_out
);
    import hsl_pkg::*;

    // Remainder stays below den << DIV_QW, so the shift never drops a set bit.
    function automatic hsl_lane_t lane_step(input hsl_lane_t l);
        logic [NUM_W-1:0] sub;
        logic             ge;
        logic [NUM_W-1:0] rem_new;
        hsl_lane_t        o;
        sub     = NUM_W'(l.den) << (DIV_QW - 1);
        ge      = (l.rem >= sub);
        rem_new = ge ? (l.rem - sub) : l.rem;
        o.rem   = rem_new << 1;
        o.den   = l.den;
        o.quo   = {l.quo[DIV_QW-2:0], ge};
        return o;
    endfunction

    logic      valid_reg;
    hsl_beat_t beat_reg, beat_next;

    always_comb
    begin
        beat_next      = beat_in;
        beat_next.hue  = lane_step(beat_in.hue);
        beat_next.sat  = lane_step(beat_in.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= beat_in.side.valid;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_comb
    begin
        beat_out            = beat_reg;
        beat_out.side.valid = valid_reg;
    end

endmodule

// File: sv/hsl_div_pipe.sv
// Chain of DIV_QW division steps; one quotient bit per stage per lane.
// Depends on hsl_pkg and hsl_div_step.
module hsl_div_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  hsl_pkg::hsl_beat_t beat_in,
    output hsl_pkg::hsl_beat_t beat_out
);
    import hsl_pkg::*;

    hsl_beat_t chain [DIV_QW+1];

    assign chain[0] = beat_in;

    for (genvar i = 0; i < DIV_QW; i++)
    begin : g_step
        hsl_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    assign beat_out = chain[DIV_QW];

endmodule

// File: sv/rgb_to_hsl_converter_top.sv
// Top level of the RGB-to-HSL converter: front end, divider pipe, output stage.
// Depends on hsl_pkg, hsl_front, hsl_div_pipe.
//
//  channel | handshake         | payload
//  --------+-------------------+-----------------------------------------
//  pixel   | start / busy      | red[7:0], green[7:0], blue[7:0]
//  result  | done (1-cycle)    | hue[14:0], saturation[12:0],
//          |                   | lightness_sum[8:0]
//
// One pixel per clock: busy is always low and a beat may be started every cycle.
// The path runs through the front end, the divider pipe, whose two restoring
// dividers retire one quotient bit a stage, and the output register.
// rst_n clears only the valid bits; in-flight beats are dropped.
// The receiver cannot stall: done pulses for exactly one cycle per beat.
module rgb_to_hsl_converter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hsl_pkg::CH_W-1:0]        red,
    input  logic [hsl_pkg::CH_W-1:0]        green,
    input  logic [hsl_pkg::CH_W-1:0]        blue,
    output logic                            done,
    output logic [hsl_pkg::HUE_W-1:0]       hue,
    output logic [hsl_pkg::SAT_W-1:0]       saturation,
    output logic [hsl_pkg::LIGHT_W-1:0]     lightness_sum
);
    import hsl_pkg::*;

    hsl_beat_t front_beat;
    hsl_beat_t div_beat;

    // Pipeline never back-pressures.
    assign busy = 1'b0;

    hsl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .beat_out (front_beat)
    );

    hsl_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat_in  (front_beat),
        .beat_out (div_beat)
    );

    // Output stage: gray override and hue wrap at full circle.
    logic               done_reg;
    logic [HUE_W-1:0]   hue_reg, hue_next;
    logic [SAT_W-1:0]   sat_reg, sat_next;
    logic [LIGHT_W-1:0] light_reg;

    always_comb
    begin
        if (div_beat.side.gray || (div_beat.hue.quo >= DIV_QW'(HUE_FULL)))
            hue_next = '0;
        else
            hue_next = HUE_W'(div_beat.hue.quo);
        sat_next = div_beat.side.gray ? '0 : SAT_W'(div_beat.sat.quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_beat.side.valid;
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= sat_next;
        light_reg <= div_beat.side.light;
    end

    assign done          = done_reg;
    assign hue           = hue_reg;
    assign saturation    = sat_reg;
    assign lightness_sum = light_reg;

endmodule

// File: sv/hsl_checker.sv
// Port-level checker for rgb_to_hsl_converter_top, attached by bind.
// Depends on hsl_pkg.
module hsl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            done,
    input  logic [hsl_pkg::HUE_W-1:0]       hue,
    input  logic [hsl_pkg::SAT_W-1:0]       saturation,
    input  logic [hsl_pkg::LIGHT_W-1:0]     lightness_sum
);
    import hsl_pkg::*;

    // Every accepted beat comes out on done after the pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted beat did not complete after pipeline latency");

    // No result without an accepted beat at the matching earlier edge.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching accepted beat");

    // Ranges of the result fields.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((hue < HUE_W'(HUE_FULL)) && (lightness_sum <= LIGHT_W'(510))
                  && (saturation <= SAT_W'(1 << SAT_FRACTION_BITS))))
        else $error("result field out of range");

    // Zero saturation only happens for gray, and gray has hue 0.
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (saturation == '0)) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

endmodule

bind rgb_to_hsl_converter_top hsl_checker u_hsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hue           (hue),
    .saturation    (saturation),
    .lightness_sum (lightness_sum)
);
